@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define RWC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RWC_ASSERT(lbl, clk, rst, prop, msg)

`define RWC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/rwc_pkg.sv @@
package rwc_pkg;

  localparam int MAP_BITS_DEFAULT = 64;

  localparam int SOURCE_W = 16;
  localparam int ID_W     = 32;
  localparam int NUMBER_W = 32;
  localparam int SPAN_W   = 7;
  localparam int CFG_W    = 32;
  localparam int INDEX_W  = 2;

  localparam logic [SOURCE_W-1:0] SOURCE_RESET     = 16'd1;
  localparam logic [ID_W-1:0]     CONNECTION_RESET = 32'd0;
  localparam logic [ID_W-1:0]     EPOCH_RESET      = 32'd0;
  localparam logic [SPAN_W-1:0]   SPAN_RESET       = 7'd64;

  typedef enum logic [INDEX_W-1:0] {
    REG_SOURCE     = 2'd0,
    REG_CONNECTION = 2'd1,
    REG_EPOCH      = 2'd2,
    REG_SPAN       = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] pkt_source;
    logic [ID_W-1:0]     pkt_connection;
    logic [ID_W-1:0]     pkt_epoch;
    logic [NUMBER_W-1:0] pkt_number;
  } item_t;

  typedef struct packed {
    logic [SOURCE_W-1:0] source;
    logic [ID_W-1:0]     connection;
    logic [ID_W-1:0]     epoch;
    logic [SPAN_W-1:0]   span;
    logic                clear;
  } cfg_t;

endpackage

@@ hw/rtl/rwc_pkt_if.sv @@
interface rwc_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [rwc_pkg::SOURCE_W-1:0]  pkt_source;
  logic [rwc_pkg::ID_W-1:0]      pkt_connection;
  logic [rwc_pkg::ID_W-1:0]      pkt_epoch;
  logic [rwc_pkg::NUMBER_W-1:0]  pkt_number;

  modport source (
    output valid, pkt_source, pkt_connection, pkt_epoch, pkt_number,
    input  ready
  );

  modport sink (
    input  valid, pkt_source, pkt_connection, pkt_epoch, pkt_number,
    output ready
  );
endinterface

@@ hw/rtl/rwc_res_if.sv @@
interface rwc_res_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (
    output valid, accepted,
    input  ready
  );

  modport sink (
    input  valid, accepted,
    output ready
  );
endinterface

@@ hw/rtl/rwc_cfg.sv @@
module rwc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rwc_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [rwc_pkg::CFG_W-1:0]     cfg_data,
  output rwc_pkg::cfg_t                 cfg
);

  logic [rwc_pkg::SOURCE_W-1:0] source;
  logic [rwc_pkg::ID_W-1:0]     connection;
  logic [rwc_pkg::ID_W-1:0]     epoch;
  logic [rwc_pkg::SPAN_W-1:0]   span;
  rwc_pkg::reg_index_t          index;

  assign index = rwc_pkg::reg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      source     <= rwc_pkg::SOURCE_RESET;
      connection <= rwc_pkg::CONNECTION_RESET;
      epoch      <= rwc_pkg::EPOCH_RESET;
      span       <= rwc_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (index)
        rwc_pkg::REG_SOURCE:     source     <= cfg_data[rwc_pkg::SOURCE_W-1:0];
        rwc_pkg::REG_CONNECTION: connection <= cfg_data[rwc_pkg::ID_W-1:0];
        rwc_pkg::REG_EPOCH:      epoch      <= cfg_data[rwc_pkg::ID_W-1:0];
        rwc_pkg::REG_SPAN:       span       <= cfg_data[rwc_pkg::SPAN_W-1:0];
        default:                 source     <= source;
      endcase
    end
  end

  // every register write restarts the window
  always_comb begin
    cfg.source     = source;
    cfg.connection = connection;
    cfg.epoch      = epoch;
    cfg.span       = span;
    cfg.clear      = cfg_we;
  end

endmodule

@@ hw/rtl/rwc_window.sv @@
`include "assert_macros.svh"

module rwc_window #(
  parameter int MAP_BITS = rwc_pkg::MAP_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  rwc_pkg::cfg_t cfg,
  input  logic          step,
  input  rwc_pkg::item_t item,
  output logic          ok
);

  localparam int SW = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
  localparam logic [rwc_pkg::NUMBER_W-1:0] MAP_LIMIT = rwc_pkg::NUMBER_W'(MAP_BITS);

  logic                          seen_any;
  logic [rwc_pkg::NUMBER_W-1:0]  highest_number;
  logic [MAP_BITS-1:0]           seen_map;

  logic                          seen_any_next;
  logic [rwc_pkg::NUMBER_W-1:0]  highest_number_next;
  logic [MAP_BITS-1:0]           seen_map_next;

  logic                          match;
  logic [rwc_pkg::NUMBER_W-1:0]  diff;
  logic [rwc_pkg::NUMBER_W-1:0]  offset;
  logic                          in_window;

  always_comb begin
    match = (item.pkt_source == cfg.source) &&
            (item.pkt_connection == cfg.connection) &&
            (item.pkt_epoch == cfg.epoch);
    diff      = item.pkt_number - highest_number;
    offset    = highest_number - item.pkt_number;
    in_window = (offset < {{(rwc_pkg::NUMBER_W-rwc_pkg::SPAN_W){1'b0}}, cfg.span}) &&
                (offset < MAP_LIMIT);

    ok                  = 1'b0;
    seen_any_next       = seen_any;
    highest_number_next = highest_number;
    seen_map_next       = seen_map;

    priority if (!match) begin
      ok = 1'b0;
    end else if (!seen_any) begin
      ok                  = 1'b1;
      seen_any_next       = 1'b1;
      highest_number_next = item.pkt_number;
      seen_map_next       = MAP_BITS'(1);
    end else if (item.pkt_number > highest_number) begin
      ok                  = 1'b1;
      highest_number_next = item.pkt_number;
      if (diff >= MAP_LIMIT) begin
        seen_map_next = MAP_BITS'(1);
      end else begin
        seen_map_next = (seen_map << diff[SW-1:0]) | MAP_BITS'(1);
      end
    end else if (in_window && !seen_map[offset[SW-1:0]]) begin
      ok            = 1'b1;
      seen_map_next = seen_map | (MAP_BITS'(1) << offset[SW-1:0]);
    end else begin
      ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      seen_any       <= 1'b0;
      highest_number <= '0;
      seen_map       <= '0;
    end else if (step) begin
      seen_any       <= seen_any_next;
      highest_number <= highest_number_next;
      seen_map       <= seen_map_next;
    end
  end

  // the highest number always has its own bit set
  `RWC_ASSERT_ALWAYS(a_top_bit_set, clk, seen_any |-> seen_map[0],
    "window: highest number bit clear")
  `RWC_ASSERT_ALWAYS(a_empty_when_unseen, clk,
    !seen_any |-> (seen_map == '0 && highest_number == '0),
    "window: state not empty before first packet")
  `RWC_ASSERT(a_rejects_keep_state, clk, rst,
    (step && !ok && !cfg.clear) |=> ($stable(seen_map) && $stable(highest_number)),
    "window: rejected packet changed state")

endmodule

@@ hw/rtl/replay_window_check.sv @@
// Anti-replay window check. Each pkt transaction carries a packet's source,
// connection and epoch ids and its 32-bit number; exactly one res transaction
// follows with accepted = 1 for a fresh packet. One packet is taken every
// cycle while res.ready is high. A packet waits in the input register and
// its result in the result register; res.valid rises when that register
// is loaded. The rate is set by the update of the highest number and the
// MAP_BITS-wide seen map, which every packet reads and writes. Any
// configuration write clears the window; write configuration only while no
// packet is in flight.
`include "assert_macros.svh"

module replay_window_check #(
  parameter int MAP_BITS = rwc_pkg::MAP_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  rwc_pkt_if.sink                      pkt,
  rwc_res_if.source                    res,
  input  logic                         cfg_we,
  input  logic [rwc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [rwc_pkg::CFG_W-1:0]    cfg_data
);

  rwc_pkg::cfg_t  cfg;
  rwc_pkg::item_t stage;
  logic           stage_valid;
  logic           out_valid;
  logic           out_accepted;
  logic           advance;
  logic           step;
  logic           take;
  logic           ok;

  rwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rwc_window #(
    .MAP_BITS (MAP_BITS)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (stage),
    .ok   (ok)
  );

  assign advance   = !out_valid || res.ready;
  assign step      = stage_valid && advance;
  assign pkt.ready = !stage_valid || advance;
  assign take      = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage.pkt_source     <= pkt.pkt_source;
      stage.pkt_connection <= pkt.pkt_connection;
      stage.pkt_epoch      <= pkt.pkt_epoch;
      stage.pkt_number     <= pkt.pkt_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_accepted <= ok;
    end
  end

  assign res.valid    = out_valid;
  assign res.accepted = out_accepted;

  // both registers full and output stalled: no new transaction
  `RWC_ASSERT(a_full_blocks_input, clk, rst,
    (stage_valid && out_valid && !res.ready) |-> !pkt.ready,
    "top: input taken while pipeline full")
  `RWC_ASSERT(a_step_fills_output, clk, rst, step |=> out_valid,
    "top: evaluated packet lost its result")
  `RWC_ASSERT(a_no_result_from_empty, clk, rst,
    (advance && !stage_valid) |=> !out_valid,
    "top: result without a packet")

endmodule
